[rtl/core/wnms_pkg.sv]
// shared constants and controller/datapath interface types for window non-max suppression
package wnms_pkg;

	localparam int WINDOW     = 11;
	localparam int HALF_WIN   = WINDOW / 2;
	localparam int RING_ROWS  = 2 * HALF_WIN + 1;
	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 1024;

	localparam int PIX_W     = 8;
	localparam int COL_W     = 10;
	localparam int ROW_W     = 10;
	localparam int SIZE_W    = 11;
	localparam int RING_W    = $clog2(RING_ROWS);
	localparam int CFG_IDX_W = 2;
	localparam int OUT_W     = 32;

	localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;

	// commands from controller to datapath
	typedef struct packed {
		logic accept;
		logic init;
		logic rd;
		logic acc;
		logic emit;
	} dp_cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic has_run;
		logic col_end;
		logic row_end;
		logic run_last;
		logic out_free;
	} dp_stat_t;

endpackage

[rtl/core/window_non_max_suppression.sv]
// top level of the streaming window non-maximum suppression block
//
//  channel | dir | handshake             | payload
//  s_      | in  | s_tvalid / s_tready   | s_tdata: pixel
//  m_      | out | m_tvalid / m_tready   | m_tdata: value, out_row, out_col; tlast, tuser
//  cfg_    | in  | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// a request writes its pixel into the line store; each result it releases then takes
// an init step, one read/compare step per neighbour of the clamped window (up to
// WINDOW*WINDOW) and an emit step; the single line store read port gives one neighbour per step.
// reset clears control state only; the line store holds garbage until written.
// a stalled m_ side holds the sweep in the emit state; s_tready is high only when idle.
module window_non_max_suppression (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [7:0]                     s_tdata,   // [7:0] pixel
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [wnms_pkg::OUT_W-1:0]     m_tdata,   // [7:0] value, [17:8] out_row, [27:18] out_col
	output logic                           m_tlast,   // last_of_run
	output logic                           m_tuser,   // end_of_frame
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [wnms_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [wnms_pkg::SIZE_W-1:0]    cfg_data
);
	import wnms_pkg::*;

	dp_cmd_t          cmd;
	dp_stat_t         stat;
	logic [PIX_W-1:0] value;
	logic [ROW_W-1:0] out_row;
	logic [COL_W-1:0] out_col;

	assign cfg_ready = 1'b1;

	wnms_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (s_tvalid),
		.req_ready (s_tready),
		.stat      (stat),
		.cmd       (cmd)
	);

	wnms_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.pixel     (s_tdata),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_idx   (cfg_index),
		.cfg_val   (cfg_data),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_value (value),
		.out_row   (out_row),
		.out_col   (out_col),
		.out_last  (m_tlast),
		.out_eof   (m_tuser)
	);

	// pack result fields
	assign m_tdata = {4'b0, out_col, out_row, value};

	// one request at a time: no new request right after one that starts a run
	a_single_req: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && stat.has_run) |=> !s_tready)
		else $error("request accepted while a run was still active");

	// frame end only on the last result of a run
	a_eof_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |-> m_tlast)
		else $error("end of frame without last of run");

	// a new result only loads when the output register is free
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (!m_tvalid || m_tready))
		else $error("result overwrote a pending output");
endmodule

[rtl/core/wnms_ctrl.sv]
// controller state machine sequencing writes, window sweeps and result emission
module wnms_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_ready,
	input  wnms_pkg::dp_stat_t stat,
	output wnms_pkg::dp_cmd_t  cmd
);
	import wnms_pkg::*;

	typedef enum logic [2:0] {ST_IDLE, ST_INIT, ST_READ, ST_ACC, ST_EMIT} state_t;
	state_t state_q;

	// command decode
	always_comb begin
		req_ready  = (state_q == ST_IDLE);
		cmd        = '0;
		cmd.accept = (state_q == ST_IDLE) && req_valid;
		cmd.init   = (state_q == ST_INIT);
		cmd.rd     = (state_q == ST_READ);
		cmd.acc    = (state_q == ST_ACC);
		cmd.emit   = (state_q == ST_EMIT) && stat.out_free;
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (req_valid && stat.has_run) state_q <= ST_INIT;
				end
				ST_INIT: state_q <= ST_READ;
				ST_READ: state_q <= ST_ACC;
				ST_ACC: begin
					if (stat.col_end && stat.row_end) state_q <= ST_EMIT;
					else state_q <= ST_READ;
				end
				ST_EMIT: begin
					if (stat.out_free) state_q <= stat.run_last ? ST_IDLE : ST_INIT;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

[rtl/core/wnms_dp.sv]
// datapath: line store, position counters, window sweep and output register
module wnms_dp (
	input  logic                           clk,
	input  logic                           arst_n,
	input  wnms_pkg::dp_cmd_t              cmd,
	output wnms_pkg::dp_stat_t             stat,
	input  logic [wnms_pkg::PIX_W-1:0]     pixel,
	input  logic                           cfg_we,
	input  logic [wnms_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [wnms_pkg::SIZE_W-1:0]    cfg_val,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [wnms_pkg::PIX_W-1:0]     out_value,
	output logic [wnms_pkg::ROW_W-1:0]     out_row,
	output logic [wnms_pkg::COL_W-1:0]     out_col,
	output logic                           out_last,
	output logic                           out_eof
);
	import wnms_pkg::*;

	localparam logic [ROW_W-1:0]  H2_R   = ROW_W'(HALF_WIN);
	localparam logic [COL_W-1:0]  H2_C   = COL_W'(HALF_WIN);
	localparam logic [RING_W-1:0] RING_L = RING_W'(RING_ROWS - 1);
	localparam logic [RING_W:0]   RING_N = (RING_W+1)'(RING_ROWS);

	logic [PIX_W-1:0] mem [RING_ROWS*MAX_WIDTH];

	logic [SIZE_W-1:0] width_q, height_q;
	logic [ROW_W-1:0]  in_row_q;
	logic [COL_W-1:0]  in_col_q;
	logic [RING_W-1:0] in_ring_q;

	logic [ROW_W-1:0]  base_row_q, r_q, r1_q, i_q, rb_q;
	logic [RING_W-1:0] base_ring_q, i_ring_q;
	logic [COL_W-1:0]  c_q, c0_q, c1_q, j_q, ca_q, cb_q;
	logic              eof_q;
	logic [PIX_W-1:0]  rdata_q, max_q, centre_q;

	logic [SIZE_W-1:0] eff_w, eff_h;
	logic [COL_W-1:0]  wm1, ic, c0, c1, ca, cb;
	logic [ROW_W-1:0]  hm1, ir, r0, r1, ra, rb;
	logic [RING_W-1:0] iring, ring_back, start_ring;
	logic [SIZE_W-1:0] r_hi, c_hi;
	logic              wrap, row_last, col_last;

	// effective frame size and current input position
	always_comb begin
		eff_w = (width_q == '0) ? SIZE_W'(1)
			: ((width_q > SIZE_W'(MAX_WIDTH)) ? SIZE_W'(MAX_WIDTH) : width_q);
		eff_h = (height_q == '0) ? SIZE_W'(1)
			: ((height_q > SIZE_W'(MAX_HEIGHT)) ? SIZE_W'(MAX_HEIGHT) : height_q);
		wm1 = COL_W'(eff_w - SIZE_W'(1));
		hm1 = ROW_W'(eff_h - SIZE_W'(1));
		wrap  = ({1'b0, in_row_q} >= eff_h) || ({1'b0, in_col_q} >= eff_w);
		ir    = wrap ? '0 : in_row_q;
		ic    = wrap ? '0 : in_col_q;
		iring = wrap ? '0 : in_ring_q;
		row_last = (ir == hm1);
		col_last = (ic == wm1);
		r0 = (ir >= H2_R) ? ir - H2_R : '0;
		r1 = row_last ? ir : r0;
		c0 = (ic >= H2_C) ? ic - H2_C : '0;
		c1 = col_last ? ic : c0;
	end

	// window bounds of the current result
	always_comb begin
		ra   = (r_q >= H2_R) ? r_q - H2_R : '0;
		r_hi = {1'b0, r_q} + SIZE_W'(HALF_WIN);
		rb   = (r_hi > {1'b0, hm1}) ? hm1 : ROW_W'(r_hi);
		ca   = (c_q >= H2_C) ? c_q - H2_C : '0;
		c_hi = {1'b0, c_q} + SIZE_W'(HALF_WIN);
		cb   = (c_hi > {1'b0, wm1}) ? wm1 : COL_W'(c_hi);
		ring_back = RING_W'(base_row_q - ra);
		start_ring = (base_ring_q >= ring_back) ? base_ring_q - ring_back
			: RING_W'({1'b0, base_ring_q} + RING_N - {1'b0, ring_back});
	end

	// status
	always_comb begin
		stat.has_run  = (row_last || ir >= H2_R) && (col_last || ic >= H2_C);
		stat.col_end  = (j_q == cb_q);
		stat.row_end  = (i_q == rb_q);
		stat.run_last = (r_q == r1_q) && (c_q == c1_q);
		stat.out_free = !out_valid || out_ready;
	end

	// line store
	always_ff @(posedge clk) begin
		if (cmd.accept) mem[{iring, ic}] <= pixel;
		if (cmd.rd) rdata_q <= mem[{i_ring_q, j_q}];
	end

	// configuration and input position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q   <= SIZE_W'(MAX_WIDTH);
			height_q  <= SIZE_W'(MAX_HEIGHT);
			in_row_q  <= '0;
			in_col_q  <= '0;
			in_ring_q <= '0;
		end else if (cfg_we && (cfg_idx == REG_WIDTH || cfg_idx == REG_HEIGHT)) begin
			if (cfg_idx == REG_WIDTH) width_q <= cfg_val;
			else height_q <= cfg_val;
			in_row_q  <= '0;
			in_col_q  <= '0;
			in_ring_q <= '0;
		end else if (cmd.accept) begin
			if (col_last) begin
				in_col_q <= '0;
				if (row_last) begin
					in_row_q  <= '0;
					in_ring_q <= '0;
				end else begin
					in_row_q  <= ir + ROW_W'(1);
					in_ring_q <= (iring == RING_L) ? '0 : iring + RING_W'(1);
				end
			end else begin
				in_row_q  <= ir;
				in_col_q  <= ic + COL_W'(1);
				in_ring_q <= iring;
			end
		end
	end

	// run setup, window sweep and result stepping
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			base_row_q  <= ir;
			base_ring_q <= iring;
			r_q   <= r0;
			r1_q  <= r1;
			c_q   <= c0;
			c0_q  <= c0;
			c1_q  <= c1;
			eof_q <= row_last && col_last;
		end
		if (cmd.init) begin
			i_q      <= ra;
			rb_q     <= rb;
			j_q      <= ca;
			ca_q     <= ca;
			cb_q     <= cb;
			i_ring_q <= start_ring;
			max_q    <= '0;
		end
		if (cmd.acc) begin
			if (rdata_q > max_q) max_q <= rdata_q;
			if (i_q == r_q && j_q == c_q) centre_q <= rdata_q;
			if (j_q == cb_q) begin
				j_q      <= ca_q;
				i_q      <= i_q + ROW_W'(1);
				i_ring_q <= (i_ring_q == RING_L) ? '0 : i_ring_q + RING_W'(1);
			end else begin
				j_q <= j_q + COL_W'(1);
			end
		end
		if (cmd.emit) begin
			if (c_q == c1_q) begin
				c_q <= c0_q;
				r_q <= r_q + ROW_W'(1);
			end else begin
				c_q <= c_q + COL_W'(1);
			end
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_value <= (centre_q >= max_q) ? centre_q : '0;
			out_row   <= r_q;
			out_col   <= c_q;
			out_last  <= stat.run_last;
			out_eof   <= stat.run_last && eof_q;
		end
	end

	// output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.emit) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end
endmodule

[verif/tb_window_non_max_suppression.sv]
// testbench for window non-max suppression: directed and random frames checked against a predictor
module tb_window_non_max_suppression;
	import wnms_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
	localparam int SETTLE_CYCLES = 300;
	localparam int TOTAL_PIXELS  = 230;

	typedef struct {
		logic [7:0]  value;
		logic [9:0]  row;
		logic [9:0]  col;
		logic        last;
		logic        eof;
	} peak_t;

	// one row of the directed part: a register write or a pixel, with an optional expected value
	typedef struct {
		logic                 is_reg;
		logic [CFG_IDX_W-1:0] idx;
		logic [SIZE_W-1:0]    data;
		logic                 has_val;
		logic [7:0]           val;
	} dir_row_t;

	logic                 clk;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [7:0]           s_tdata;   // [7:0] pixel
	logic                 m_tvalid;
	logic                 m_tready;
	logic [OUT_W-1:0]     m_tdata;   // [7:0] value, [17:8] out_row, [27:18] out_col
	logic                 m_tlast;   // last_of_run
	logic                 m_tuser;   // end_of_frame
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [SIZE_W-1:0]    cfg_data;

	window_non_max_suppression u_dut (.*);

	// predictor state
	logic [7:0]  ring [RING_ROWS][MAX_WIDTH];
	logic [10:0] raw_width;
	logic [10:0] raw_height;
	int          next_row;
	int          next_col;
	peak_t       peak_q[$];

	bit failed;
	int results_seen;
	int pixels_sent;
	int burst_left;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#60000000;
		$display("Mismatches found");
		$finish;
	end

	function automatic int eff_size(logic [10:0] v, int maxv);
		if (v == 0) return 1;
		if (v > maxv) return maxv;
		return v;
	endfunction

	function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [SIZE_W-1:0] d);
		if (idx == REG_WIDTH) raw_width = d;
		else if (idx == REG_HEIGHT) raw_height = d;
		else return;
		next_row = 0;
		next_col = 0;
	endfunction

	function automatic logic [7:0] neighborhood_max(int r, int c, int w, int h);
		int ra, rb, ca, cb;
		logic [7:0] m;
		ra = (r >= HALF_WIN) ? r - HALF_WIN : 0;
		rb = (r + HALF_WIN > h - 1) ? h - 1 : r + HALF_WIN;
		ca = (c >= HALF_WIN) ? c - HALF_WIN : 0;
		cb = (c + HALF_WIN > w - 1) ? w - 1 : c + HALF_WIN;
		m = 8'd0;
		for (int i = ra; i <= rb; i++)
			for (int j = ca; j <= cb; j++)
				if (ring[i % RING_ROWS][j] > m) m = ring[i % RING_ROWS][j];
		return m;
	endfunction

	// store one pixel and queue every peak decision its arrival completes
	function automatic int predict_peaks(logic [7:0] p);
		int w, h, ir, ic, r0, r1, c0, c1, n;
		peak_t e;
		w = eff_size(raw_width, MAX_WIDTH);
		h = eff_size(raw_height, MAX_HEIGHT);
		ir = next_row;
		ic = next_col;
		if (ir >= h || ic >= w) begin
			ir = 0;
			ic = 0;
		end
		ring[ir % RING_ROWS][ic] = p;
		r0 = 1; r1 = 0; c0 = 1; c1 = 0; n = 0;
		if (ir == h - 1) begin
			r0 = (ir >= HALF_WIN) ? ir - HALF_WIN : 0;
			r1 = ir;
		end else if (ir >= HALF_WIN) begin
			r0 = ir - HALF_WIN;
			r1 = r0;
		end
		if (ic == w - 1) begin
			c0 = (ic >= HALF_WIN) ? ic - HALF_WIN : 0;
			c1 = ic;
		end else if (ic >= HALF_WIN) begin
			c0 = ic - HALF_WIN;
			c1 = c0;
		end
		if (r0 <= r1 && c0 <= c1) begin
			for (int r = r0; r <= r1; r++)
				for (int c = c0; c <= c1; c++) begin
					e.value = (ring[r % RING_ROWS][c] >= neighborhood_max(r, c, w, h)) ?
						ring[r % RING_ROWS][c] : 8'd0;
					e.row  = r[9:0];
					e.col  = c[9:0];
					e.last = (r == r1 && c == c1);
					e.eof  = e.last && ir == h - 1 && ic == w - 1;
					peak_q.insert(peak_q.size(), e);
					n++;
				end
		end
		ic++;
		if (ic >= w) begin
			ic = 0;
			ir++;
			if (ir >= h) ir = 0;
		end
		next_row = ir;
		next_col = ic;
		return n;
	endfunction

	// pixel request with bursty gaps
	task automatic send_pixel(logic [7:0] p);
		bit ok;
		int g;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 20);
			g = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
			if (g > 0) begin
				s_tvalid <= 1'b0;
				repeat (g) @(posedge clk);
			end
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tdata  <= p;
		do begin
			@(negedge clk);
			ok = s_tready;
			@(posedge clk);
		end while (!ok);
		void'(predict_peaks(p));
		pixels_sent++;
	endtask

	// wait for every queued result, then let the block settle
	task automatic drain();
		s_tvalid <= 1'b0;
		while (peak_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [SIZE_W-1:0] d);
		bit ok;
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= d;
		do begin
			@(negedge clk);
			ok = cfg_ready;
			@(posedge clk);
		end while (!ok);
		apply_reg(idx, d);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// receiver: changing stall pattern plus one long hold-off while pixels are offered
	initial begin
		int mode, mode_left, hold_left;
		bit held;
		m_tready = 1'b0;
		mode = 0; mode_left = 0; hold_left = 0; held = 0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (!held && results_seen >= 60 && s_tvalid) begin
				held = 1;
				hold_left = 4000;
				m_tready <= 1'b0;
			end else begin
				if (mode_left == 0) begin
					mode = $urandom_range(0, 2);
					mode_left = $urandom_range(20, 200);
				end
				mode_left--;
				case (mode)
					0: m_tready <= 1'b1;
					1: m_tready <= 1'($urandom_range(0, 1));
					default: m_tready <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	// result checker, sampled before the edge that accepts the result
	always @(negedge clk) begin
		peak_t e;
		if (arst_n && m_tvalid && m_tready) begin
			results_seen++;
			if (peak_q.size() == 0) begin
				$error("unexpected result: value %0d row %0d col %0d",
					m_tdata[7:0], m_tdata[17:8], m_tdata[27:18]);
				failed = 1;
			end else begin
				e = peak_q.pop_front();
				if (m_tdata[7:0] !== e.value) begin
					$error("value: expected %0d, got %0d", e.value, m_tdata[7:0]);
					failed = 1;
				end
				if (m_tdata[17:8] !== e.row) begin
					$error("out_row: expected %0d, got %0d", e.row, m_tdata[17:8]);
					failed = 1;
				end
				if (m_tdata[27:18] !== e.col) begin
					$error("out_col: expected %0d, got %0d", e.col, m_tdata[27:18]);
					failed = 1;
				end
				if (m_tlast !== e.last) begin
					$error("last_of_run: expected %0d, got %0d", e.last, m_tlast);
					failed = 1;
				end
				if (m_tuser !== e.eof) begin
					$error("end_of_frame: expected %0d, got %0d", e.eof, m_tuser);
					failed = 1;
				end
			end
		end
	end

	// stimulus
	initial begin
		dir_row_t dir_rows[$];
		int w, h, n, mode, k;
		bit paused;
		logic [7:0] p;
		s_tvalid = 1'b0; s_tdata = 8'd0;
		cfg_valid = 1'b0; cfg_index = REG_WIDTH; cfg_data = '0;
		raw_width = 11'd1024; raw_height = 11'd1024;
		next_row = 0; next_col = 0;
		failed = 0; results_seen = 0; pixels_sent = 0; burst_left = 0; paused = 0;
		arst_n = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// zero sizes act as a single pixel frame; unknown index is ignored
		dir_rows = '{
			'{1, REG_WIDTH,  11'd0,    0, 8'd0},
			'{1, REG_HEIGHT, 11'd0,    0, 8'd0},
			'{0, REG_WIDTH,  11'd255,  1, 8'd255},
			'{0, REG_WIDTH,  11'd0,    1, 8'd0},
			'{1, REG_UNUSED, 11'd5,    0, 8'd0},
			'{0, REG_WIDTH,  11'd128,  1, 8'd128},
			// oversized width saturates, one row only
			'{1, REG_WIDTH,  11'd2047, 0, 8'd0},
			'{1, REG_HEIGHT, 11'd1,    0, 8'd0},
			'{0, REG_WIDTH,  11'd0,    0, 8'd0},
			'{0, REG_WIDTH,  11'd255,  0, 8'd0},
			'{0, REG_WIDTH,  11'd7,    0, 8'd0},
			'{0, REG_WIDTH,  11'd255,  0, 8'd0},
			'{0, REG_WIDTH,  11'd3,    0, 8'd0},
			'{0, REG_WIDTH,  11'd1,    0, 8'd0},
			'{0, REG_WIDTH,  11'd0,    0, 8'd0},
			// single column, tallest frame
			'{1, REG_WIDTH,  11'd1,    0, 8'd0},
			'{1, REG_HEIGHT, 11'd1024, 0, 8'd0},
			'{0, REG_WIDTH,  11'd9,    0, 8'd0},
			'{0, REG_WIDTH,  11'd9,    0, 8'd0},
			'{0, REG_WIDTH,  11'd200,  0, 8'd0},
			'{0, REG_WIDTH,  11'd0,    0, 8'd0},
			'{0, REG_WIDTH,  11'd255,  0, 8'd0},
			'{0, REG_WIDTH,  11'd1,    0, 8'd0},
			'{0, REG_WIDTH,  11'd1,    0, 8'd0}
		};
		foreach (dir_rows[i]) begin
			if (dir_rows[i].is_reg) begin
				drain();
				write_reg(dir_rows[i].idx, dir_rows[i].data);
			end else begin
				send_pixel(dir_rows[i].data[7:0]);
				if (dir_rows[i].has_val && peak_q.size() != 0 &&
					peak_q[$].value !== dir_rows[i].val) begin
					$error("value: expected %0d, got %0d", dir_rows[i].val, peak_q[$].value);
					failed = 1;
				end
			end
		end

		// random frames: mostly whole frames of small size, some cut short
		while (pixels_sent < TOTAL_PIXELS) begin
			drain();
			if ($urandom_range(0, 9) == 0) begin
				w = $urandom_range(900, 1024);
				h = $urandom_range(1, 2);
				n = $urandom_range(10, 30);
			end else begin
				w = $urandom_range(1, 14);
				h = $urandom_range(1, 10);
				n = w * h * $urandom_range(1, 2);
				if ($urandom_range(0, 4) == 0) n = $urandom_range(1, w * h);
			end
			if (n > TOTAL_PIXELS - pixels_sent) n = TOTAL_PIXELS - pixels_sent;
			write_reg(REG_WIDTH, w[SIZE_W-1:0]);
			write_reg(REG_HEIGHT, h[SIZE_W-1:0]);
			mode = $urandom_range(0, 2);
			for (k = 0; k < n; k++) begin
				case (mode)
					0: p = 8'($urandom_range(0, 255));
					1: p = 8'($urandom_range(0, 3));
					default: p = ($urandom_range(0, 3) == 0) ? 8'd0 : 8'd255;
				endcase
				if (!paused && pixels_sent >= 150 && k > 0) begin
					paused = 1;
					s_tvalid <= 1'b0;
					@(posedge clk);
					while (peak_q.size() != 0) @(posedge clk);
				end
				send_pixel(p);
			end
		end
		drain();

		if (!failed) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
